FILE: rtl/yuv420_pkg.sv
// ----------------------------------------------------------------------------
// yuv420_pkg
// Shared types, constants and helpers of the planar 4:2:0 to RGB converter.
// ----------------------------------------------------------------------------
package yuv420_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 11;
    localparam int CW_W      = 10;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_block;
        logic       end_of_frame;
    } out_item_t;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
        logic       last_of_block;
        logic       end_of_frame;
    } pix_meta_t;

    typedef struct packed {
        logic can_issue;
        logic slot_busy;
    } pix_status_t;

    typedef enum logic [2:0] {
        ST_GEOM,
        ST_SIZE,
        ST_WRAP,
        ST_DIV_WAIT,
        ST_ROWBASE,
        ST_IDLE,
        ST_TERMS,
        ST_ISSUE
    } ctrl_state_t;

    // even size, at least 2, at most the even bound
    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] reg_val,
                                                   input int lim_in);
        logic [12:0] lim;
        logic [12:0] v;
        lim = 13'(lim_in) & 13'h1FFE;
        v   = {2'b00, reg_val & 11'h7FE};
        if (lim < 13'd2) begin
            lim = 13'd2;
        end
        if (v < 13'd2) begin
            v = 13'd2;
        end
        if (v > lim) begin
            v = lim;
        end
        return v[CFG_W-1:0];
    endfunction

    // floor shift by 8, clamp to 0..255
    function automatic logic [7:0] clamp_channel(input logic signed [19:0] s);
        logic [7:0] r;
        if (s[19]) begin
            r = 8'd0;
        end else if (s[18:16] != 3'd0) begin
            r = 8'd255;
        end else begin
            r = s[15:8];
        end
        return r;
    endfunction

endpackage

FILE: rtl/yuv420_ram.sv
// ----------------------------------------------------------------------------
// yuv420_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module yuv420_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/yuv420_div.sv
// ----------------------------------------------------------------------------
// yuv420_div
// Restoring divider, one quotient bit per cycle, used to rebuild the chroma
// column and row from the byte position after a size change.
// ----------------------------------------------------------------------------
module yuv420_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             active_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                active_reg <= 1'b1;
                count_reg  <= '0;
            end else if (active_reg) begin
                count_reg <= count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(NUM_W - 1)) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
        end else if (active_reg) begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

FILE: rtl/yuv420_pix.sv
// ----------------------------------------------------------------------------
// yuv420_pix
// Color conversion: chroma terms per block, luma term per pixel, clamp, and
// the output register of the result channel.
// ----------------------------------------------------------------------------
module yuv420_pix (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load_terms,
    input  logic [7:0]               u_byte,
    input  logic [7:0]               v_byte,
    input  logic                     issue,
    input  yuv420_pkg::pix_meta_t    meta_in,
    input  logic [7:0]               luma_byte,
    output yuv420_pkg::pix_status_t  status,
    output logic                     m_valid,
    input  logic                     m_ready,
    output yuv420_pkg::out_item_t    m_data
);

    logic signed [9:0]  d_s;
    logic signed [9:0]  e_s;
    logic signed [19:0] tr_c;
    logic signed [19:0] tg_c;
    logic signed [19:0] tb_c;
    logic signed [19:0] tr_reg;
    logic signed [19:0] tg_reg;
    logic signed [19:0] tb_reg;
    logic signed [19:0] c_s;
    logic signed [19:0] r_s;
    logic signed [19:0] g_s;
    logic signed [19:0] b_s;

    logic                   rdv_reg;
    yuv420_pkg::pix_meta_t  meta_reg;
    logic                   m_valid_reg;
    yuv420_pkg::out_item_t  m_data_reg;
    logic                   load_out;

    // chroma terms, rounding constant folded in
    assign d_s  = $signed({2'b00, u_byte}) - 10'sd128;
    assign e_s  = $signed({2'b00, v_byte}) - 10'sd128;
    assign tr_c = 20'sd409 * 20'(e_s) + 20'sd128;
    assign tg_c = 20'sd128 - 20'sd100 * 20'(d_s) - 20'sd208 * 20'(e_s);
    assign tb_c = 20'sd516 * 20'(d_s) + 20'sd128;

    always_ff @(posedge aclk) begin
        if (load_terms) begin
            tr_reg <= tr_c;
            tg_reg <= tg_c;
            tb_reg <= tb_c;
        end
    end

    assign c_s = 20'sd298 * (20'($signed({1'b0, luma_byte})) - 20'sd16);
    assign r_s = c_s + tr_reg;
    assign g_s = c_s + tg_reg;
    assign b_s = c_s + tb_reg;

    assign load_out         = rdv_reg && (!m_valid_reg || m_ready);
    assign status.can_issue = !rdv_reg || load_out;
    assign status.slot_busy = rdv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rdv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (issue) begin
                rdv_reg <= 1'b1;
            end else if (load_out) begin
                rdv_reg <= 1'b0;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            meta_reg <= meta_in;
        end
        if (load_out) begin
            m_data_reg.pixel_x       <= meta_reg.pixel_x;
            m_data_reg.pixel_y       <= meta_reg.pixel_y;
            m_data_reg.red           <= yuv420_pkg::clamp_channel(r_s);
            m_data_reg.green         <= yuv420_pkg::clamp_channel(g_s);
            m_data_reg.blue          <= yuv420_pkg::clamp_channel(b_s);
            m_data_reg.last_of_block <= meta_reg.last_of_block;
            m_data_reg.end_of_frame  <= meta_reg.end_of_frame;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/planar_yuv420_to_rgb.sv
// ----------------------------------------------------------------------------
// planar_yuv420_to_rgb
// Planar 4:2:0 byte stream to RGB pixels, BT.601 limited range. Luma and U
// planes go to on-chip memories; each V byte reads them back and emits the
// four pixels of its 2x2 block.
//
//   channel  | direction | handshake          | payload
//   s_       | in        | s_valid / s_ready  | in_item_t (data byte, start flag)
//   m_       | out       | m_valid / m_ready  | out_item_t (x, y, rgb, flags)
//   cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (width, height)
//
// a luma or U byte is one memory write; a V byte is accepted with its chroma
// read, then takes four reads of the single luma read port; a next V byte
// waits for the last pixel to leave the slot; after reset s_ready stays low
// through ST_GEOM, ST_SIZE and ST_WRAP, after a size write as well, and then
// through the bit-serial divider and ST_ROWBASE if the position is in the V plane
// a stalled result channel holds the block once one pixel waits in the
// output register and one in the read slot
// ----------------------------------------------------------------------------
module planar_yuv420_to_rgb #(
    parameter int MAX_WIDTH  = yuv420_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = yuv420_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  yuv420_pkg::in_item_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output yuv420_pkg::out_item_t               m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [yuv420_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [yuv420_pkg::CFG_W-1:0]        cfg_data
);

    localparam int LUMA_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int CHROMA_DEPTH = LUMA_DEPTH / 4;
    localparam int LA_W         = $clog2(LUMA_DEPTH);
    localparam int CA_W         = (CHROMA_DEPTH > 1) ? $clog2(CHROMA_DEPTH) : 1;
    localparam int POS_W        = $clog2(LUMA_DEPTH + LUMA_DEPTH / 2 + 1);
    localparam int CY_W         = (MAX_HEIGHT / 2 > 1) ? $clog2(MAX_HEIGHT / 2) : 1;
    localparam int YS_W         = (CY_W + 1 > 10) ? CY_W + 1 : 10;
    localparam int CFG_W        = yuv420_pkg::CFG_W;
    localparam int CW_W         = yuv420_pkg::CW_W;

    yuv420_pkg::ctrl_state_t state_reg, state_next;

    logic [CFG_W-1:0] cfg_width_reg;
    logic [CFG_W-1:0] cfg_height_reg;
    logic             dirty_reg;

    logic [CFG_W-1:0]   eff_w;
    logic [CFG_W-1:0]   eff_h;
    logic [2*CFG_W-1:0] area;
    logic [CFG_W-1:0]   w_reg;
    logic [CW_W-1:0]    cw_reg;
    logic [POS_W-1:0]   luma_n_reg;
    logic [POS_W-1:0]   vstart_reg;
    logic [POS_W-1:0]   total_reg;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [CW_W-1:0]  cx_reg;
    logic [CY_W-1:0]  cy_reg;
    logic [POS_W-1:0] row_base_reg;
    logic [CY_W+CFG_W-1:0] row_prod;

    logic [7:0]       e_reg;
    logic [POS_W-1:0] base_reg;
    logic [CFG_W-1:0] x0_reg;
    logic [CY_W:0]    y0_reg;
    logic             eof_reg;
    logic [1:0]       idx_reg;

    logic [POS_W-1:0] pos_eff;
    logic [POS_W-1:0] pos_inc;
    logic             pos_wrap;
    logic             in_luma;
    logic             in_v;
    logic             reg_in_v;
    logic [POS_W-1:0] u_off;
    logic [POS_W-1:0] v_off;
    logic [POS_W-1:0] laddr;
    logic [CFG_W-1:0] xsum;
    logic [YS_W-1:0]  ysum;
    logic             accept;
    logic             cfg_write;
    logic             issue;
    logic             div_start;
    logic             load_terms;

    logic             div_done;
    logic [POS_W-1:0] div_quo;
    logic [CW_W-1:0]  div_rem;

    logic [7:0]       luma_rd;
    logic [7:0]       chroma_rd;

    yuv420_pkg::pix_meta_t   meta;
    yuv420_pkg::pix_status_t pix_status;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign eff_w = yuv420_pkg::eff_size(cfg_width_reg, MAX_WIDTH);
    assign eff_h = yuv420_pkg::eff_size(cfg_height_reg, MAX_HEIGHT);
    assign area  = eff_w * eff_h;

    assign row_prod = {{CFG_W{1'b0}}, cy_reg} * {{CY_W{1'b0}}, w_reg};

    assign pos_eff  = s_data.start_of_frame ? '0 : pos_reg;
    assign pos_inc  = pos_eff + POS_W'(1);
    assign pos_wrap = (pos_inc == total_reg);
    assign pos_next = pos_wrap ? '0 : pos_inc;
    assign in_luma  = (pos_eff < luma_n_reg);
    assign in_v     = (pos_eff >= vstart_reg);
    assign reg_in_v = (pos_reg >= vstart_reg) && (pos_reg < total_reg);
    assign u_off    = pos_eff - luma_n_reg;
    assign v_off    = pos_eff - vstart_reg;
    assign accept   = s_valid && s_ready;

    assign laddr = base_reg + POS_W'(idx_reg[0]) + (idx_reg[1] ? POS_W'(w_reg) : '0);
    assign xsum  = x0_reg + CFG_W'(idx_reg[0]);
    assign ysum  = YS_W'(y0_reg) + YS_W'(idx_reg[1]);

    assign meta.pixel_x       = xsum[9:0];
    assign meta.pixel_y       = ysum[9:0];
    assign meta.last_of_block = (idx_reg == 2'd3);
    assign meta.end_of_frame  = eof_reg && (idx_reg == 2'd3);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            yuv420_pkg::ST_GEOM: begin
                state_next = yuv420_pkg::ST_SIZE;
            end
            yuv420_pkg::ST_SIZE: begin
                state_next = yuv420_pkg::ST_WRAP;
            end
            yuv420_pkg::ST_WRAP: begin
                state_next = reg_in_v ? yuv420_pkg::ST_DIV_WAIT : yuv420_pkg::ST_IDLE;
            end
            yuv420_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = yuv420_pkg::ST_ROWBASE;
                end
            end
            yuv420_pkg::ST_ROWBASE: begin
                state_next = yuv420_pkg::ST_IDLE;
            end
            yuv420_pkg::ST_IDLE: begin
                priority if (dirty_reg) begin
                    state_next = yuv420_pkg::ST_GEOM;
                end else if (accept && in_v) begin
                    state_next = yuv420_pkg::ST_TERMS;
                end
            end
            yuv420_pkg::ST_TERMS: begin
                state_next = yuv420_pkg::ST_ISSUE;
            end
            yuv420_pkg::ST_ISSUE: begin
                if (issue && idx_reg == 2'd3) begin
                    state_next = yuv420_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = yuv420_pkg::ST_GEOM;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready    = 1'b0;
        issue      = 1'b0;
        div_start  = 1'b0;
        load_terms = 1'b0;
        unique case (state_reg)
            yuv420_pkg::ST_IDLE: begin
                s_ready = !dirty_reg
                          && !((pos_reg >= vstart_reg) && pix_status.slot_busy);
            end
            yuv420_pkg::ST_WRAP: begin
                div_start = reg_in_v;
            end
            yuv420_pkg::ST_TERMS: begin
                load_terms = 1'b1;
            end
            yuv420_pkg::ST_ISSUE: begin
                issue = pix_status.can_issue;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= yuv420_pkg::ST_GEOM;
            cfg_width_reg  <= yuv420_pkg::RST_FRAME_WIDTH;
            cfg_height_reg <= yuv420_pkg::RST_FRAME_HEIGHT;
            dirty_reg      <= 1'b0;
            pos_reg        <= '0;
            idx_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_write) begin
                unique case (cfg_index)
                    yuv420_pkg::REG_FRAME_WIDTH:  cfg_width_reg  <= cfg_data;
                    yuv420_pkg::REG_FRAME_HEIGHT: cfg_height_reg <= cfg_data;
                endcase
                dirty_reg <= 1'b1;
            end else if (state_reg == yuv420_pkg::ST_GEOM) begin
                dirty_reg <= 1'b0;
            end
            if (state_reg == yuv420_pkg::ST_WRAP && pos_reg >= total_reg) begin
                pos_reg <= '0;
            end else if (accept) begin
                pos_reg <= pos_next;
            end
            if (accept) begin
                idx_reg <= '0;
            end else if (issue) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // geometry and position tracking
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            yuv420_pkg::ST_GEOM: begin
                luma_n_reg <= POS_W'(area);
                w_reg      <= eff_w;
                cw_reg     <= eff_w[CFG_W-1:1];
            end
            yuv420_pkg::ST_SIZE: begin
                vstart_reg <= luma_n_reg + (luma_n_reg >> 2);
                total_reg  <= luma_n_reg + (luma_n_reg >> 1);
            end
            yuv420_pkg::ST_WRAP: begin
                if (!reg_in_v) begin
                    cx_reg       <= '0;
                    cy_reg       <= '0;
                    row_base_reg <= '0;
                end
            end
            yuv420_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    cx_reg <= div_rem;
                    cy_reg <= CY_W'(div_quo);
                end
            end
            yuv420_pkg::ST_ROWBASE: begin
                row_base_reg <= POS_W'({row_prod, 1'b0});
            end
            yuv420_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_v) begin
                        e_reg    <= s_data.data_byte;
                        base_reg <= row_base_reg + POS_W'({cx_reg, 1'b0});
                        x0_reg   <= {cx_reg, 1'b0};
                        y0_reg   <= {cy_reg, 1'b0};
                        eof_reg  <= pos_wrap;
                        if (cx_reg + CW_W'(1) == cw_reg) begin
                            cx_reg       <= '0;
                            cy_reg       <= cy_reg + CY_W'(1);
                            row_base_reg <= row_base_reg + POS_W'({w_reg, 1'b0});
                        end else begin
                            cx_reg <= cx_reg + CW_W'(1);
                        end
                    end else begin
                        cx_reg       <= '0;
                        cy_reg       <= '0;
                        row_base_reg <= '0;
                    end
                end
            end
            default: begin
                cx_reg <= cx_reg;
            end
        endcase
    end

    yuv420_div #(
        .NUM_W (POS_W),
        .DEN_W (CW_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (pos_reg - vstart_reg),
        .den     (cw_reg),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    yuv420_ram #(
        .WIDTH (8),
        .DEPTH (LUMA_DEPTH),
        .AW    (LA_W)
    ) u_luma_ram (
        .aclk    (aclk),
        .wr_en   (accept && in_luma),
        .wr_addr (pos_eff[LA_W-1:0]),
        .wr_data (s_data.data_byte),
        .rd_en   (issue),
        .rd_addr (laddr[LA_W-1:0]),
        .rd_data (luma_rd)
    );

    yuv420_ram #(
        .WIDTH (8),
        .DEPTH (CHROMA_DEPTH),
        .AW    (CA_W)
    ) u_chroma_ram (
        .aclk    (aclk),
        .wr_en   (accept && !in_luma && !in_v),
        .wr_addr (u_off[CA_W-1:0]),
        .wr_data (s_data.data_byte),
        .rd_en   (accept && in_v),
        .rd_addr (v_off[CA_W-1:0]),
        .rd_data (chroma_rd)
    );

    yuv420_pix u_pix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_terms (load_terms),
        .u_byte     (chroma_rd),
        .v_byte     (e_reg),
        .issue      (issue),
        .meta_in    (meta),
        .luma_byte  (luma_rd),
        .status     (pix_status),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

FILE: test/tb_planar_yuv420_to_rgb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_planar_yuv420_to_rgb
// Feeds planar 4:2:0 frames byte by byte into the converter and checks every
// emitted pixel against a behavioral predictor of the block. Frame sizes are
// changed between phases. Both handshakes stall at random. A frame of at most
// BIG_LUMA luma bytes that is larger than any before it is sent complete
// first, so no pixel reads a luma or U entry that was never written.
// ----------------------------------------------------------------------------
module tb_planar_yuv420_to_rgb;

    localparam int          CFG_W       = yuv420_pkg::CFG_W;
    localparam int          CFG_IDX_W   = yuv420_pkg::CFG_IDX_W;
    localparam int          STIM_GOAL   = 360;
    localparam int          STALL_LIMIT = 4000;
    localparam int unsigned BIG_LUMA    = 1024;
    localparam int unsigned LAST_BYTES  = 144;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    yuv420_pkg::in_item_t  s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    yuv420_pkg::out_item_t m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    yuv420_pkg::in_item_t  pending_bytes[$];
    yuv420_pkg::out_item_t expected_pixels[$];
    yuv420_pkg::out_item_t want;
    logic [7:0]  luma_mem[int unsigned];
    logic [7:0]  udiff_mem[int unsigned];
    logic [CFG_W-1:0] width_shadow  = yuv420_pkg::RST_FRAME_WIDTH;
    logic [CFG_W-1:0] height_shadow = yuv420_pkg::RST_FRAME_HEIGHT;
    int unsigned frame_pos   = 0;
    int unsigned luma_filled = 0;
    int unsigned fed_bytes   = 0;
    int          mismatches  = 0;
    int          quiet_cycles = 0;
    int          src_gap     = 0;
    int          sink_gap    = 0;
    bit          calm        = 1'b0;

    planar_yuv420_to_rgb u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned effective_dim(input logic [CFG_W-1:0] raw,
                                                  input int unsigned bound);
        int unsigned dim;
        int unsigned lim;
        dim = {raw[CFG_W-1:1], 1'b0};
        lim = bound & ~32'd1;
        if (lim < 2) begin
            lim = 2;
        end
        if (dim < 2) begin
            dim = 2;
        end
        if (dim > lim) begin
            dim = lim;
        end
        return dim;
    endfunction

    function automatic logic [7:0] to_channel(input int acc);
        int v;
        if (acc < 0) begin
            return 8'd0;
        end
        v = acc >>> 8;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // stores luma and U, turns each V byte into its four pixels
    function automatic void convert_byte(input yuv420_pkg::in_item_t it);
        int unsigned w, h, luma_n, cw, chroma_n, total, k, cx, cy, x, y;
        int          d, e, c;
        yuv420_pkg::out_item_t px;
        w        = effective_dim(width_shadow, yuv420_pkg::DEF_MAX_WIDTH);
        h        = effective_dim(height_shadow, yuv420_pkg::DEF_MAX_HEIGHT);
        luma_n   = w * h;
        cw       = w / 2;
        chroma_n = cw * (h / 2);
        total    = luma_n + 2 * chroma_n;
        if (it.start_of_frame) begin
            frame_pos = 0;
        end
        if (frame_pos >= total) begin
            frame_pos = 0;
        end
        if (frame_pos < luma_n) begin
            luma_mem[frame_pos] = it.data_byte;
        end else if (frame_pos < luma_n + chroma_n) begin
            udiff_mem[frame_pos - luma_n] = it.data_byte;
        end else begin
            k  = frame_pos - luma_n - chroma_n;
            cx = k % cw;
            cy = k / cw;
            d  = int'(udiff_mem[k]) - 128;
            e  = int'(it.data_byte) - 128;
            for (int i = 0; i < 4; i++) begin
                x = 2 * cx + (i & 1);
                y = 2 * cy + (i >> 1);
                c = 298 * (int'(luma_mem[y * w + x]) - 16);
                px.pixel_x       = 10'(x);
                px.pixel_y       = 10'(y);
                px.red           = to_channel(c + 409 * e + 128);
                px.green         = to_channel(c - 100 * d - 208 * e + 128);
                px.blue          = to_channel(c + 516 * d + 128);
                px.last_of_block = (i == 3);
                px.end_of_frame  = (i == 3) && (frame_pos + 1 == total);
                expected_pixels.insert(expected_pixels.size(), px);
            end
        end
        frame_pos = frame_pos + 1;
        if (frame_pos >= total) begin
            frame_pos = 0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [9:0] got,
                               input logic [9:0] exp_v);
        if (got !== exp_v) begin
            report_mismatch($sformatf("pixel (%0d,%0d) %s: got %0d, expected %0d",
                                      want.pixel_x, want.pixel_y, name, got, exp_v));
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                convert_byte(s_data);
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_bytes.pop_front();
                    if (!calm && $urandom_range(0, 7) == 0) begin
                        src_gap = $urandom_range(1, 3);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel (%0d,%0d)",
                                              m_data.pixel_x, m_data.pixel_y));
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_x", m_data.pixel_x, want.pixel_x);
                    check_field("pixel_y", m_data.pixel_y, want.pixel_y);
                    check_field("red", 10'(m_data.red), 10'(want.red));
                    check_field("green", 10'(m_data.green), 10'(want.green));
                    check_field("blue", 10'(m_data.blue), 10'(want.blue));
                    check_field("last_of_block", 10'(m_data.last_of_block),
                                10'(want.last_of_block));
                    check_field("end_of_frame", 10'(m_data.end_of_frame),
                                10'(want.end_of_frame));
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) begin
                    sink_gap = $urandom_range(1, 3);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void push_byte(input logic [7:0] value, input logic sof);
        yuv420_pkg::in_item_t it;
        it.data_byte      = value;
        it.start_of_frame = sof;
        pending_bytes.insert(pending_bytes.size(), it);
    endfunction

    function automatic void push_run(input logic sof_first, input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            push_byte(8'($urandom_range(0, 255)), sof_first && (i == 0));
        end
        fed_bytes += count;
    endfunction

    task automatic wait_drained(input int settle);
        do begin
            @(negedge aclk);
        end while (pending_bytes.size() != 0 || s_valid || expected_pixels.size() != 0);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == yuv420_pkg::REG_FRAME_WIDTH) begin
            width_shadow = value;
        end else begin
            height_shadow = value;
        end
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
        write_reg(yuv420_pkg::REG_FRAME_WIDTH, w_raw);
        write_reg(yuv420_pkg::REG_FRAME_HEIGHT, h_raw);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw,
                             input bit no_idle);
        int unsigned luma_n, total, goal, first;
        wait_drained(16);
        calm = no_idle;
        set_geometry(w_raw, h_raw);
        luma_n = effective_dim(w_raw, yuv420_pkg::DEF_MAX_WIDTH)
                 * effective_dim(h_raw, yuv420_pkg::DEF_MAX_HEIGHT);
        total  = luma_n + luma_n / 2;
        first  = fed_bytes;
        if (luma_n > BIG_LUMA) begin
            // large frames: a few luma bytes only, no pixel comes out
            push_run(1'($urandom_range(0, 1)), $urandom_range(8, 30));
        end else begin
            if (luma_n > luma_filled) begin
                push_run(1'b1, total);
                luma_filled = luma_n;
            end
            goal = $urandom_range(20, 60);
            for (int half = 1; half <= 2; half++) begin
                while (fed_bytes - first < goal * half / 2) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: push_run(1'b1, total);
                        6: push_run(1'b0, total);
                        7: push_run(1'b1, $urandom_range(1, total - 1));
                        default: begin
                            repeat ($urandom_range(1, 6)) begin
                                push_byte(8'($urandom_range(0, 255)),
                                          $urandom_range(0, 7) == 0);
                                fed_bytes++;
                            end
                        end
                    endcase
                end
                if (half == 1) begin
                    wait_drained(0);
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry, luma only
        push_byte(8'h10, 1'b1);
        push_byte(8'h80, 1'b0);
        wait_drained(16);

        // odd and too small sizes collapse to 2x2
        set_geometry(11'd3, 11'd1);
        push_byte(8'd0, 1'b1);
        push_byte(8'd255, 1'b0);
        push_byte(8'd16, 1'b0);
        push_byte(8'd235, 1'b0);
        push_byte(8'd0, 1'b0);
        push_byte(8'd255, 1'b0);
        push_byte(8'd255, 1'b1);
        push_byte(8'd255, 1'b0);
        push_byte(8'd255, 1'b0);
        push_byte(8'd255, 1'b0);
        push_byte(8'd255, 1'b0);
        push_byte(8'd0, 1'b0);
        // next frame follows the wrap without a start flag
        push_byte(8'd16, 1'b0);
        push_byte(8'd16, 1'b0);
        push_byte(8'd16, 1'b0);
        push_byte(8'd16, 1'b0);
        push_byte(8'd255, 1'b0);
        push_byte(8'd255, 1'b0);
        // stray byte, then resync
        push_byte(8'h55, 1'b0);
        push_byte(8'd235, 1'b1);
        push_byte(8'd235, 1'b0);
        push_byte(8'd0, 1'b0);
        push_byte(8'd0, 1'b0);
        push_byte(8'd128, 1'b0);
        push_byte(8'd0, 1'b0);
        luma_filled = 4;

        run_phase(11'd2047, 11'd1025, 1'b0);
        while (fed_bytes + LAST_BYTES < STIM_GOAL) begin
            if ($urandom_range(0, 5) == 0) begin
                if ($urandom_range(0, 1) == 1) begin
                    run_phase(CFG_W'($urandom_range(1024, 2047)),
                              CFG_W'($urandom_range(0, 2047)), 1'b0);
                end else begin
                    run_phase(CFG_W'($urandom_range(0, 2047)),
                              CFG_W'($urandom_range(1024, 2047)), 1'b0);
                end
            end else begin
                run_phase(CFG_W'($urandom_range(0, 13)), CFG_W'($urandom_range(0, 9)),
                          $urandom_range(0, 3) == 0);
            end
        end
        run_phase(11'd12, 11'd8, 1'b1);

        wait_drained(40);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
